// ===== rtl/core/memory_region_table_defines.svh =====
// Assertion macros for the region table checker
`ifndef MEMORY_REGION_TABLE_DEFINES_SVH
`define MEMORY_REGION_TABLE_DEFINES_SVH

// Same-cycle implication, reset masks it
`define MRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks it
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mrt_pkg.sv =====
package mrt_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_W      = $clog2(PAGE_BYTES);
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // flag bit positions
  localparam int FLAG_READ_BIT  = 0;
  localparam int FLAG_WRITE_BIT = 1;
  localparam int FLAG_STACK_BIT = 3;

  // configuration register indexes
  localparam logic CFG_USER_BASE = 1'b0;
  localparam logic CFG_USER_TOP  = 1'b1;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_FIND  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] stop;
    logic [3:0]  perms;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  // compare results of one entry against the probe range
  typedef struct packed {
    logic contains;    // start <= lo < stop
    logic overlap;     // start < hi && lo < stop
    logic start_gt_lo; // start > lo
    logic stop_ge_hi;  // stop >= hi
    logic first_page;  // lo - start < page
  } cmp_res_t;

endpackage

// ===== rtl/core/mrt_cmp.sv =====
module mrt_cmp (
  input  mrt_pkg::entry_t   entry,
  input  logic [63:0]       probe_lo,
  input  logic [63:0]       probe_hi,
  output mrt_pkg::cmp_res_t res
);
  import mrt_pkg::*;

  logic        lo_ge_start;
  logic        lo_lt_stop;
  logic [63:0] diff;

  // shared bound comparator used by every scan step
  always_comb begin
    lo_ge_start     = probe_lo >= entry.start;
    lo_lt_stop      = probe_lo < entry.stop;
    diff            = probe_lo - entry.start;
    res.contains    = lo_ge_start && lo_lt_stop;
    res.overlap     = (entry.start < probe_hi) && lo_lt_stop;
    res.start_gt_lo = !lo_ge_start;
    res.stop_ge_hi  = entry.stop >= probe_hi;
    res.first_page  = diff[63:PAGE_W] == '0;
  end

endmodule

// ===== rtl/core/mrt_table.sv =====
module mrt_table (
  input  logic                       clk,
  input  logic [mrt_pkg::IDX_W-1:0]  rd_idx,
  output mrt_pkg::entry_t            rd_data,
  input  mrt_pkg::tbl_wr_t           wr
);
  import mrt_pkg::*;

  entry_t mem_r [MAX_REGIONS];

  // single write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
  end

  // single read port
  assign rd_data = mem_r[rd_idx];

endmodule

// ===== rtl/core/memory_region_table.sv =====
// Region table: map, find, check and clear, one result per item.
// Clear answers from the prep state, as do map and check when the range fails the window;
// find and check scan the table; map scans, then, unless the table is full, shifts the
// entries behind the insert position up and writes the new region. The scan walks the table
// one entry per cycle through the shared comparator. One item in flight: the next input is
// taken as the result is offered. Reset (rst_n low, synchronous): table empty, window defaults.
module memory_region_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // address[63:0], length[127:64], perm_flags[131:128], is_write[132], zero pad
  input  logic [135:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // status[1:0], found[2], region_start[66:3], region_end[130:67],
  // region_perms[134:131], access_ok[135]
  output logic [135:0]  out_tdata,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_wdata
);
  import mrt_pkg::*;

  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [63:0]      lo_r, lo_nxt;
  logic [63:0]      hi_r, hi_nxt;
  logic [3:0]       perm_r, perm_nxt;
  logic             wr_r, wr_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             located_r, located_nxt;
  logic [63:0]      user_base_r, user_top_r;

  // staged result
  status_t          res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  entry_t           res_entry_r, res_entry_nxt;
  logic             res_ok_r, res_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [135:0]     out_data_r, out_data_nxt;

  logic [64:0]        top_sum;
  logic [64-PAGE_W:0] up_sum;
  logic [63:0]        map_start, map_end;
  logic               map_carry;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_entry;
  cmp_res_t           cmp;
  tbl_wr_t            tbl_wr;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // read one entry behind while shifting up
  always_comb begin
    if (state_r == S_SHIFT) begin
      rd_idx = IDX_W'(idx_r - CNT_W'(1));
    end else begin
      rd_idx = idx_r[IDX_W-1:0];
    end
  end

  mrt_table u_table (
    .clk     (clk),
    .rd_idx  (rd_idx),
    .rd_data (rd_entry),
    .wr      (tbl_wr)
  );

  mrt_cmp u_cmp (
    .entry    (rd_entry),
    .probe_lo (lo_r),
    .probe_hi (hi_r),
    .res      (cmp)
  );

  // page rounding of the latched range
  always_comb begin
    top_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    up_sum    = {1'b0, top_sum[63:PAGE_W]} + (65-PAGE_W)'(1);
    map_start = {lo_r[63:PAGE_W], {PAGE_W{1'b0}}};
    if (top_sum[PAGE_W-1:0] != '0) begin
      map_end   = {up_sum[63-PAGE_W:0], {PAGE_W{1'b0}}};
      map_carry = up_sum[64-PAGE_W];
    end else begin
      map_end   = top_sum[63:0];
      map_carry = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    perm_nxt       = perm_r;
    wr_nxt         = wr_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    located_nxt    = located_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_entry_nxt  = res_entry_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    tbl_wr.en      = 1'b0;
    tbl_wr.idx     = idx_r[IDX_W-1:0];
    tbl_wr.data    = rd_entry;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt       = kind_t'(in_tuser);
          lo_nxt         = in_tdata[63:0];
          hi_nxt         = in_tdata[127:64];
          perm_nxt       = in_tdata[131:128];
          wr_nxt         = in_tdata[132];
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_entry_nxt  = '0;
          res_ok_nxt     = 1'b0;
          idx_nxt        = '0;
          located_nxt    = 1'b0;
          state_nxt      = S_PREP;
        end
      end

      S_PREP: begin
        pos_nxt = count_r;
        unique case (kind_r)
          KIND_MAP: begin
            lo_nxt = map_start;
            hi_nxt = map_end;
            if (top_sum[64] || map_carry || !(user_base_r <= map_start &&
                map_start < map_end && map_end <= user_top_r)) begin
              res_status_nxt = ST_INVALID;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          KIND_FIND: begin
            state_nxt = S_SCAN;
          end
          KIND_CHECK: begin
            hi_nxt = top_sum[63:0];
            if (top_sum[64] || !(user_base_r <= lo_r && lo_r < top_sum[63:0] &&
                top_sum[63:0] <= user_top_r)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCAN: begin
        if (idx_r == count_r) begin
          // end of table reached
          if (kind_r == KIND_MAP) begin
            if (count_r == CNT_W'(MAX_REGIONS)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          unique case (kind_r)
            KIND_MAP: begin
              if (cmp.overlap) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_DONE;
              end else if (cmp.start_gt_lo && pos_r == count_r) begin
                pos_nxt = idx_r;
              end
            end
            KIND_FIND: begin
              if (cmp.contains) begin
                res_found_nxt = 1'b1;
                res_entry_nxt = rd_entry;
                state_nxt     = S_DONE;
              end
            end
            default: begin
              if (cmp.contains) begin
                if ((wr_r && !rd_entry.perms[FLAG_WRITE_BIT]) ||
                    (!wr_r && !rd_entry.perms[FLAG_READ_BIT]) ||
                    (wr_r && rd_entry.perms[FLAG_STACK_BIT] && cmp.first_page)) begin
                  state_nxt = S_DONE;
                end else if (cmp.stop_ge_hi) begin
                  res_ok_nxt = 1'b1;
                  state_nxt  = S_DONE;
                end else begin
                  lo_nxt      = rd_entry.stop;
                  located_nxt = 1'b1;
                end
              end else if (located_r) begin
                // gap after a covering region
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          tbl_wr.en = 1'b1;
          idx_nxt   = idx_r - CNT_W'(1);
        end
      end

      S_PUT: begin
        tbl_wr.en          = 1'b1;
        tbl_wr.idx         = pos_r[IDX_W-1:0];
        tbl_wr.data.start  = lo_r;
        tbl_wr.data.stop   = hi_r;
        tbl_wr.data.perms  = perm_r;
        count_nxt          = count_r + CNT_W'(1);
        res_found_nxt      = 1'b1;
        res_entry_nxt      = tbl_wr.data;
        state_nxt          = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_ok_r, res_entry_r.perms, res_entry_r.stop,
                           res_entry_r.start, res_found_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      user_base_r <= 64'h0000_0000_0020_0000;
      user_top_r  <= 64'h0000_0000_8000_0000;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en && cfg_index == CFG_USER_BASE) begin
        user_base_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == CFG_USER_TOP) begin
        user_top_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    perm_r       <= perm_nxt;
    wr_r         <= wr_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    located_r    <= located_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_entry_r  <= res_entry_nxt;
    res_ok_r     <= res_ok_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== rtl/core/mrt_checker.sv =====
`include "memory_region_table_defines.svh"

module mrt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);
  import mrt_pkg::*;

  // a stalled result stays offered
  `MRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  // block is busy right after taking an item
  `MRT_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready, "ready after transfer")
  // found only goes with ok status
  `MRT_ASSERT_NOW(a_found_ok, out_tvalid && out_tdata[2], out_tdata[1:0] == ST_OK, "found with error status")
  // status code in range
  `MRT_ASSERT_NOW(a_status, out_tvalid, out_tdata[1:0] <= ST_FULL, "bad status")

endmodule

bind memory_region_table mrt_checker u_mrt_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mrt_pkg::*;

  // one result as it appears on the master side
  typedef struct {
    status_t     status;
    bit          found;
    bit [63:0]   rstart;
    bit [63:0]   rend;
    bit [3:0]    rperms;
    bit          access_ok;
  } region_result_t;

  // Region table predictor plus the queue of results still owed by the block
  class region_scoreboard;
    bit [63:0]      base_q;
    bit [63:0]      top_q;
    bit [63:0]      tbl_start [MAX_REGIONS];
    bit [63:0]      tbl_end [MAX_REGIONS];
    bit [3:0]       tbl_perms [MAX_REGIONS];
    int             tbl_count;
    region_result_t owed[$];
    int             mismatches;
    int             n_inserted, n_full, n_found, n_access_ok, n_checked;

    function new();
      base_q = 64'h20_0000;
      top_q = 64'h8000_0000;
      tbl_count = 0;
      mismatches = 0;
    endfunction

    function bit in_window(bit [63:0] lo, bit [63:0] hi);
      return base_q <= lo && lo < hi && hi <= top_q;
    endfunction

    function int locate(bit [63:0] addr);
      for (int i = 0; i < tbl_count; i++)
        if (tbl_start[i] <= addr && addr < tbl_end[i]) return i;
      return -1;
    endfunction

    function void fill_region(ref region_result_t r, input int i);
      r.found = 1'b1;
      r.rstart = tbl_start[i];
      r.rend = tbl_end[i];
      r.rperms = tbl_perms[i];
    endfunction

    function void map_region(bit [63:0] a, bit [63:0] l, bit [3:0] f, ref region_result_t r);
      bit [64:0] top65;
      bit [64:0] end65;
      bit [63:0] lo;
      bit [63:0] hi;
      int pos;
      top65 = {1'b0, a} + {1'b0, l};
      if (top65[64]) begin
        r.status = ST_INVALID;
        return;
      end
      lo = a - (a % 64'(PAGE_BYTES));
      end65 = top65;
      if (top65[63:0] % 64'(PAGE_BYTES) != 0)
        end65 = top65 + 65'(64'(PAGE_BYTES) - top65[63:0] % 64'(PAGE_BYTES));
      if (end65[64] || !in_window(lo, end65[63:0])) begin
        r.status = ST_INVALID;
        return;
      end
      hi = end65[63:0];
      for (int i = 0; i < tbl_count; i++)
        if (tbl_start[i] < hi && lo < tbl_end[i]) begin
          r.status = ST_INVALID;
          return;
        end
      if (tbl_count >= MAX_REGIONS) begin
        r.status = ST_FULL;
        n_full++;
        return;
      end
      pos = tbl_count;
      for (int i = 0; i < tbl_count; i++)
        if (tbl_start[i] > lo) begin
          pos = i;
          break;
        end
      for (int i = tbl_count; i > pos; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_end[i] = tbl_end[i-1];
        tbl_perms[i] = tbl_perms[i-1];
      end
      tbl_start[pos] = lo;
      tbl_end[pos] = hi;
      tbl_perms[pos] = f;
      tbl_count++;
      n_inserted++;
      fill_region(r, pos);
    endfunction

    function bit access_allowed(bit [63:0] a, bit [63:0] l, bit wr);
      bit [64:0] end65;
      bit [63:0] cur;
      int k;
      int need_bit;
      end65 = {1'b0, a} + {1'b0, l};
      if (end65[64] || !in_window(a, end65[63:0])) return 1'b0;
      need_bit = wr ? FLAG_WRITE_BIT : FLAG_READ_BIT;
      cur = a;
      for (int steps = 0; cur < end65[63:0] && steps <= MAX_REGIONS; steps++) begin
        k = locate(cur);
        if (k < 0) return 1'b0;
        if (!tbl_perms[k][need_bit]) return 1'b0;
        if (wr && tbl_perms[k][FLAG_STACK_BIT] && cur - tbl_start[k] < 64'(PAGE_BYTES))
          return 1'b0;
        cur = tbl_end[k];
      end
      return cur >= end65[63:0];
    endfunction

    // accepted input transfer: work out what the block must answer
    function void note_input(kind_t k, bit [63:0] a, bit [63:0] l, bit [3:0] f, bit wr);
      region_result_t r;
      int idx;
      r = '{ST_OK, 1'b0, 64'd0, 64'd0, 4'd0, 1'b0};
      case (k)
        KIND_MAP: map_region(a, l, f, r);
        KIND_FIND: begin
          idx = locate(a);
          if (idx >= 0) begin
            fill_region(r, idx);
            n_found++;
          end
        end
        KIND_CHECK: begin
          r.access_ok = access_allowed(a, l, wr);
          n_checked++;
          if (r.access_ok) n_access_ok++;
        end
        default: tbl_count = 0;
      endcase
      owed.push_back(r);
    endfunction

    function void report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endfunction

    // accepted result transfer: compare against the oldest expectation
    function void check_result(bit [135:0] d);
      region_result_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", d));
        return;
      end
      e = owed.pop_front();
      if (d[1:0] != e.status)
        report_mismatch($sformatf("status %0d, want %0d", d[1:0], e.status));
      if (d[2] != e.found)
        report_mismatch($sformatf("found %0d, want %0d", d[2], e.found));
      if (d[66:3] != e.rstart)
        report_mismatch($sformatf("region_start %h, want %h", d[66:3], e.rstart));
      if (d[130:67] != e.rend)
        report_mismatch($sformatf("region_end %h, want %h", d[130:67], e.rend));
      if (d[134:131] != e.rperms)
        report_mismatch($sformatf("region_perms %h, want %h", d[134:131], e.rperms));
      if (d[135] != e.access_ok)
        report_mismatch($sformatf("access_ok %0d, want %0d", d[135], e.access_ok));
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         cfg_wr_en;
  logic         cfg_index;
  logic [63:0]  cfg_wdata;

  region_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit timed_out;

  memory_region_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: sample, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer, with random idle cycles in front
  task automatic send_item(kind_t k, bit [63:0] a, bit [63:0] l, bit [3:0] f, bit wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {3'b000, wr, f, l, a};
    do @(posedge clk); while (!in_tready);
    sb.note_input(k, a, l, f, wr);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_window(bit [63:0] lo, bit [63:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_USER_BASE;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_USER_TOP;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.base_q = lo;
    sb.top_q = hi;
  endtask

  // mostly plausible traffic near the bottom of the window, some pure noise
  task automatic random_item();
    bit [63:0] a;
    bit [63:0] l;
    int sel;
    sel = $urandom_range(99);
    a = sb.base_q + 64'(PAGE_BYTES) * $urandom_range(0, 200) +
        ($urandom_range(3) == 0 ? 64'($urandom_range(PAGE_BYTES - 1)) : 64'd0);
    l = 64'(PAGE_BYTES) * $urandom_range(0, 6) +
        ($urandom_range(3) == 0 ? 64'($urandom_range(PAGE_BYTES - 1)) : 64'd0);
    if (sel < 10) begin
      a = {$urandom, $urandom};
      l = {$urandom, $urandom};
      if ($urandom_range(1)) l = l >> $urandom_range(63);
      send_item(kind_t'($urandom_range(2)), a, l, 4'($urandom), 1'($urandom));
    end else if (sel < 12) begin
      send_item(KIND_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom),
                1'($urandom));
    end else if (sel < 46) begin
      send_item(KIND_MAP, a, l, 4'($urandom), 1'($urandom));
    end else if (sel < 66) begin
      send_item(KIND_FIND, a, l, 4'($urandom), 1'($urandom));
    end else begin
      send_item(KIND_CHECK, a, l, 4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    timed_out = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 85;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_FIND;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_USER_BASE;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window, carries, overlap, stack page, spans, clear
    send_item(KIND_MAP, 64'h20_0000, 64'h1000, 4'h3, 1'b0);
    send_item(KIND_MAP, 64'h20_0800, 64'h10, 4'h1, 1'b0);
    send_item(KIND_MAP, 64'h0, 64'h1000, 4'h3, 1'b0);
    send_item(KIND_MAP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 4'h3, 1'b0);
    send_item(KIND_MAP, 64'hFFFF_FFFF_FFFF_F001, 64'h0, 4'h3, 1'b0);
    send_item(KIND_MAP, 64'h40_0000, 64'h0, 4'h3, 1'b0);
    send_item(KIND_MAP, 64'h20_1123, 64'h1000, 4'h3, 1'b1);
    send_item(KIND_MAP, 64'h30_0000, 64'h3000, 4'hB, 1'b0);
    send_item(KIND_MAP, 64'h7FFF_F000, 64'h1000, 4'hF, 1'b0);
    send_item(KIND_MAP, 64'h7FFF_F000, 64'h1001, 4'h4, 1'b0);
    send_item(KIND_FIND, 64'h20_0FFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1);
    send_item(KIND_FIND, 64'h50_0000, 64'h0, 4'h0, 1'b0);
    send_item(KIND_CHECK, 64'h20_0000, 64'h3000, 4'h0, 1'b0);
    send_item(KIND_CHECK, 64'h20_0000, 64'h3001, 4'h0, 1'b1);
    send_item(KIND_CHECK, 64'h30_0FF0, 64'h20, 4'h0, 1'b1);
    send_item(KIND_CHECK, 64'h30_1000, 64'h2000, 4'h0, 1'b1);
    send_item(KIND_CHECK, 64'h30_1000, 64'h0, 4'h0, 1'b0);
    send_item(KIND_CHECK, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 4'h0, 1'b0);
    send_item(KIND_CHECK, 64'h7FFF_F000, 64'h1000, 4'h0, 1'b1);
    send_item(KIND_CHECK, 64'h7FFF_F000, 64'h1001, 4'h0, 1'b0);
    send_item(KIND_CLEAR, 64'h0, 64'h0, 4'h0, 1'b0);
    send_item(KIND_FIND, 64'h20_0000, 64'h0, 4'h0, 1'b0);

    // random phases over several window settings and idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: write_window(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        2: write_window(64'h1000_0000, 64'h1000_0000);
        3: write_window(64'hFFFF_FFFF_FFF0_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        4: write_window(64'h20_0000, 64'h8000_0000);
        default: ;
      endcase
      send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 85 : 0;
      recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 34 : 0;
      for (int n = 0; n < ((ph == 2) ? 50 : 300); n++) begin
        if (ph == 0 && n == 150) begin
          in_tvalid <= 1'b0;
          while (sb.owed.size() != 0) @(posedge clk);
        end
        random_item();
      end
    end
    drain();

    $display("Covered %0d inserts, %0d table-full refusals, %0d finds hit,",
             sb.n_inserted, sb.n_full, sb.n_found);
    $display("%0d of %0d access checks allowed, over five window settings.",
             sb.n_access_ok, sb.n_checked);
    if (sb.mismatches == 0 && !timed_out) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    timed_out = 1'b1;
    $display("tb failed");
    $finish;
  end

endmodule
